@@ rtl/yuvfx_pkg.sv @@
`timescale 1ns / 1ps

package yuvfx_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int PAIR_W    = $clog2(MAX_WIDTH / 2);
  localparam int LINE_W    = $clog2(MAX_HEIGHT);
  localparam int MAX_PAIRS = MAX_WIDTH / 2;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_FIELD_MODE   = 2'd2,
    REG_FIELD_SELECT = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_FULL   = 2'd0,
    MODE_TOP    = 2'd1,
    MODE_BOTTOM = 2'd2,
    MODE_SEQ    = 2'd3
  } field_mode_t;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_y_even;
    logic [7:0] out_u_even;
    logic [7:0] out_v_even;
    logic [7:0] out_y_odd;
    logic [7:0] out_u_odd;
    logic [7:0] out_v_odd;
    logic       line_end;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [PAIR_W:0] pairs;
    logic [LINE_W:0] lines;
    logic            field_on;
    logic            want_odd;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    logic      keep;
    out_item_t item;
  } beat_t;

endpackage

@@ rtl/yuvfx_cfg.sv @@
`timescale 1ns / 1ps

module yuvfx_cfg
  import yuvfx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  field_mode_t      field_mode;
  logic             field_select;
  logic [CFG_W-2:0] half_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      field_mode   <= MODE_FULL;
      field_select <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_FIELD_MODE:   field_mode   <= field_mode_t'(cfg_data[1:0]);
        REG_FIELD_SELECT: field_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign half_width = frame_width[CFG_W-1:1];

  // clamp pairs per line and lines per frame
  always_comb begin
    if (half_width == '0) begin
      cfg.pairs = (PAIR_W+1)'(1);
    end else if (CFG_W'(half_width) > CFG_W'(MAX_PAIRS)) begin
      cfg.pairs = (PAIR_W+1)'(MAX_PAIRS);
    end else begin
      cfg.pairs = (PAIR_W+1)'(half_width);
    end
    if (frame_height == '0) begin
      cfg.lines = (LINE_W+1)'(1);
    end else if ((CFG_W+1)'(frame_height) > (CFG_W+1)'(MAX_HEIGHT)) begin
      cfg.lines = (LINE_W+1)'(MAX_HEIGHT);
    end else begin
      cfg.lines = (LINE_W+1)'(frame_height);
    end
    cfg.field_on = (field_mode != MODE_FULL);
    case (field_mode)
      MODE_TOP:    cfg.want_odd = 1'b0;
      MODE_BOTTOM: cfg.want_odd = 1'b1;
      MODE_SEQ:    cfg.want_odd = field_select;
      default:     cfg.want_odd = 1'b0;
    endcase
  end

endmodule

@@ rtl/yuvfx_scan.sv @@
`timescale 1ns / 1ps

module yuvfx_scan
  import yuvfx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     out_take,
  output beat_t    beat,
  output logic     beat_move
);

  logic [PAIR_W-1:0] pair_column;
  logic [LINE_W-1:0] line_number;
  logic              last_col;
  logic              last_line;
  logic              near_end;
  logic              keep;
  logic              fend;
  logic              accept;

  assign last_col  = ((PAIR_W+1)'(pair_column) + (PAIR_W+1)'(1)) >= cfg.pairs;
  assign last_line = ((LINE_W+1)'(line_number) + (LINE_W+1)'(1)) >= cfg.lines;
  assign near_end  = ((LINE_W+1)'(line_number) + (LINE_W+1)'(2)) >= cfg.lines;
  assign keep      = !cfg.field_on || (line_number[0] == cfg.want_odd);
  assign fend      = last_col && (cfg.field_on ? near_end : last_line);

  // drop skipped lines, move kept beats once the output register has room
  assign beat_move = beat.valid && (!beat.keep || out_take);
  assign in_stall  = beat.valid && !beat_move;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_column <= '0;
      line_number <= '0;
      beat.valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (last_col) begin
          pair_column <= '0;
          line_number <= last_line ? '0 : line_number + LINE_W'(1);
        end else begin
          pair_column <= pair_column + PAIR_W'(1);
        end
        beat.valid <= 1'b1;
      end else if (beat_move) begin
        beat.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat.keep                <= keep;
      beat.item.out_y_even     <= in_data.luma_first;
      beat.item.out_u_even     <= in_data.chroma_blue;
      beat.item.out_v_even     <= in_data.chroma_red;
      beat.item.out_y_odd      <= in_data.luma_second;
      beat.item.out_u_odd      <= in_data.chroma_blue;
      beat.item.out_v_odd      <= in_data.chroma_red;
      beat.item.line_end       <= last_col;
      beat.item.frame_end      <= fend;
    end
  end

endmodule

@@ rtl/yuvfx_out.sv @@
`timescale 1ns / 1ps

module yuvfx_out
  import yuvfx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  beat_t     beat,
  input  logic      beat_move,
  output logic      out_take,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic load;

  assign out_take = !out_valid || !out_stall;
  assign load     = beat_move && beat.keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= beat.item;
    end
  end

endmodule

@@ rtl/yuyv_to_yuv444_field_extract_top.sv @@
`timescale 1ns / 1ps

// YUYV 4:2:2 macropixel to YUV 4:4:4 pixel pair converter with field extraction.
// Input channel: one macropixel (Y0 U Y1 V) per beat in raster order, taken
// when in_valid is high and in_stall is low. Output channel: one pixel pair per
// kept macropixel, chroma duplicated, with line_end on the last pair of a line
// and frame_end on the last pair of the output frame. Lines of the unwanted
// parity in field modes advance the line counter and produce no beat.
// An accepted macropixel passes the input stage register, then the output
// register. Throughput while out_stall is low: one macropixel per cycle, set by
// the input stage and output registers, each passing one beat per cycle.
// A stalled output holds its beat; one more kept beat is taken into the
// input stage register, after which in_stall rises until the output drains.
// Beats of skipped lines keep passing the input stage and are dropped.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 width,
// 1 height, 2 field mode, 3 field select); write only while idle.
// Reset clears the pair and line counters, empties both stages and restores
// 640 x 480, full-frame mode, even field.

module yuyv_to_yuv444_field_extract_top
  import yuvfx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  cfg_t  cfg;
  beat_t beat;
  logic  beat_move;
  logic  out_take;

  yuvfx_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  yuvfx_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_take  (out_take),
    .beat      (beat),
    .beat_move (beat_move)
  );

  yuvfx_out u_out (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .beat_move (beat_move),
    .out_take  (out_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/yuvfx_chk.sv @@
`timescale 1ns / 1ps

module yuvfx_chk
  import yuvfx_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_chroma_dup: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.out_u_odd == out_data.out_u_even &&
                  out_data.out_v_odd == out_data.out_v_even)
    else $error("chroma not duplicated");

  a_frame_on_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_end |-> out_data.line_end)
    else $error("frame_end without line_end");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

endmodule

bind yuyv_to_yuv444_field_extract_top yuvfx_chk u_yuvfx_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/sv/yuyv_to_yuv444_field_extract_top_tb.sv @@
`timescale 1ns / 1ps

module yuyv_to_yuv444_field_extract_top_tb;
  import yuvfx_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;

  yuyv_to_yuv444_field_extract_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block's registers and counters
  logic [CFG_W-1:0] cur_width  = WIDTH_RESET;
  logic [CFG_W-1:0] cur_height = HEIGHT_RESET;
  field_mode_t      cur_mode   = MODE_FULL;
  logic             cur_select = 1'b0;
  int               col_count  = 0;
  int               line_count = 0;

  in_item_t  macropixel_queue[$];
  out_item_t pair_queue[$];
  int        fail_cnt = 0;

  bit send_idle  = 1'b0;
  bit stall_idle = 1'b0;
  bit hold_req   = 1'b0;
  int gap_left   = 0;
  int stall_left = 0;
  int hold_left  = 0;
  logic in_took  = 1'b0;

  function automatic int pause_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit convert_macropixel(in_item_t px, output out_item_t pair);
    int   pairs;
    int   lines;
    bit   last_col;
    bit   last_line;
    bit   keep;
    bit   fend;
    logic want;
    pairs = int'(cur_width) / 2;
    if (pairs < 1) pairs = 1;
    if (pairs > MAX_WIDTH / 2) pairs = MAX_WIDTH / 2;
    lines = int'(cur_height);
    if (lines < 1) lines = 1;
    if (lines > MAX_HEIGHT) lines = MAX_HEIGHT;
    last_col  = (col_count + 1) >= pairs;
    last_line = (line_count + 1) >= lines;
    if (cur_mode == MODE_FULL) begin
      keep = 1'b1;
      fend = last_col && last_line;
    end else begin
      case (cur_mode)
        MODE_TOP:    want = 1'b0;
        MODE_BOTTOM: want = 1'b1;
        default:     want = cur_select;
      endcase
      keep = (line_count[0] == want);
      fend = last_col && ((line_count + 2) >= lines);
    end
    pair.out_y_even = px.luma_first;
    pair.out_u_even = px.chroma_blue;
    pair.out_v_even = px.chroma_red;
    pair.out_y_odd  = px.luma_second;
    pair.out_u_odd  = px.chroma_blue;
    pair.out_v_odd  = px.chroma_red;
    pair.line_end   = last_col;
    pair.frame_end  = fend;
    if (last_col) begin
      col_count  = 0;
      line_count = last_line ? 0 : line_count + 1;
    end else begin
      col_count = col_count + 1;
    end
    return keep;
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_cnt++;
    end
  endtask

  // predict on input beats, check output beats
  always @(posedge clk) begin
    out_item_t pair;
    out_item_t want;
    in_took <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      if (convert_macropixel(in_data, pair)) pair_queue.push_back(pair);
    end
    if (!rst && out_valid && !out_stall) begin
      if (pair_queue.size() == 0) begin
        $error("unexpected output beat %h", out_data);
        fail_cnt++;
      end else begin
        want = pair_queue.pop_front();
        check_field("out_y_even", int'(want.out_y_even), int'(out_data.out_y_even));
        check_field("out_u_even", int'(want.out_u_even), int'(out_data.out_u_even));
        check_field("out_v_even", int'(want.out_v_even), int'(out_data.out_v_even));
        check_field("out_y_odd",  int'(want.out_y_odd),  int'(out_data.out_y_odd));
        check_field("out_u_odd",  int'(want.out_u_odd),  int'(out_data.out_u_odd));
        check_field("out_v_odd",  int'(want.out_v_odd),  int'(out_data.out_v_odd));
        check_field("line_end",   int'(want.line_end),   int'(out_data.line_end));
        check_field("frame_end",  int'(want.frame_end),  int'(out_data.frame_end));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (macropixel_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= macropixel_queue.pop_front();
        if (send_idle && $urandom_range(0, 3) == 0) gap_left = pause_length();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 300;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_idle && $urandom_range(0, 3) == 0) begin
      stall_left = pause_length() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  cur_width  = val;
      REG_FRAME_HEIGHT: cur_height = val;
      REG_FIELD_MODE:   cur_mode   = field_mode_t'(val[1:0]);
      default:          cur_select = val[0];
    endcase
  endtask

  task automatic set_frame(int w, int h, field_mode_t mode, bit sel);
    write_reg(REG_FRAME_WIDTH, CFG_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
    write_reg(REG_FIELD_MODE, CFG_W'(mode));
    write_reg(REG_FIELD_SELECT, CFG_W'(sel));
  endtask

  // wait for all beats to leave, then for skipped items still in the pipe
  task automatic drain();
    while (macropixel_queue.size() != 0 || in_valid || pair_queue.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic push_random(int count);
    repeat (count) macropixel_queue.push_back(in_item_t'($urandom));
  endtask

  initial begin
    int sent;
    int batch;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset configuration
    macropixel_queue.push_back(in_item_t'(32'h00000000));
    macropixel_queue.push_back(in_item_t'(32'hFFFFFFFF));
    macropixel_queue.push_back(in_item_t'(32'h12345678));
    drain();

    // full frame, odd height
    set_frame(4, 3, MODE_FULL, 1'b0);
    macropixel_queue.push_back(in_item_t'(32'hAA55AA55));
    macropixel_queue.push_back(in_item_t'(32'h55AA55AA));
    macropixel_queue.push_back(in_item_t'(32'hFF00FF00));
    macropixel_queue.push_back(in_item_t'(32'h00FF00FF));
    macropixel_queue.push_back(in_item_t'(32'h0F0FF0F0));
    macropixel_queue.push_back(in_item_t'(32'hF0F00F0F));
    drain();

    // odd width, top field, odd height
    set_frame(5, 3, MODE_TOP, 1'b0);
    push_random(6);
    drain();

    // bottom field with no odd line: no results
    set_frame(4, 1, MODE_BOTTOM, 1'b0);
    push_random(2);
    drain();

    // width below range, selected odd field
    set_frame(1, 2, MODE_SEQ, 1'b1);
    push_random(4);
    drain();

    // width above range clamps, height zero
    set_frame(8191, 0, MODE_FULL, 1'b0);
    push_random(32);
    drain();

    // width zero, height above range clamps
    set_frame(0, 8191, MODE_SEQ, 1'b1);
    push_random(32);
    drain();

    sent = 0;
    while (sent < 500) begin
      if (sent == 0) begin
        set_frame($urandom_range(2, 12), $urandom_range(2, 6), MODE_FULL, 1'b0);
        send_idle  = 1'b0;
        stall_idle = 1'b0;
        hold_req   = 1'b1;
        batch = 120;
      end else begin
        if ($urandom_range(0, 1))
          write_reg(REG_FRAME_WIDTH, ($urandom_range(0, 4) != 0) ?
                    CFG_W'($urandom_range(0, 12)) : CFG_W'($urandom_range(0, 8191)));
        if ($urandom_range(0, 1))
          write_reg(REG_FRAME_HEIGHT, ($urandom_range(0, 4) != 0) ?
                    CFG_W'($urandom_range(0, 7)) : CFG_W'($urandom_range(0, 8191)));
        if ($urandom_range(0, 1))
          write_reg(REG_FIELD_MODE, CFG_W'($urandom_range(0, 8191)));
        if ($urandom_range(0, 1))
          write_reg(REG_FIELD_SELECT, CFG_W'($urandom_range(0, 8191)));
        send_idle  = ($urandom_range(0, 3) != 0);
        stall_idle = ($urandom_range(0, 3) != 0);
        batch = $urandom_range(10, 60);
      end
      push_random(batch);
      sent += batch;
      drain();
    end

    repeat (10) @(negedge clk);
    if (fail_cnt == 0 && pair_queue.size() == 0) begin
      $display("yuyv_to_yuv444_field_extract_top: match");
    end else begin
      $display("yuyv_to_yuv444_field_extract_top: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("yuyv_to_yuv444_field_extract_top: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/yuvfx_pkg.sv
rtl/yuvfx_cfg.sv
rtl/yuvfx_scan.sv
rtl/yuvfx_out.sv
rtl/yuyv_to_yuv444_field_extract_top.sv
rtl/yuvfx_chk.sv
tb/sv/yuyv_to_yuv444_field_extract_top_tb.sv
